// ===== hw/rtl/gsl_pkg.sv =====
package gsl_pkg;

   localparam int unsigned CODE_W = 3;
   localparam int unsigned ROW_W = 4;
   localparam int unsigned COL_W = 5;
   localparam int unsigned CNT_W = 10;
   localparam int unsigned TOT_W = 12;
   localparam int unsigned XPOS_W = 15;
   localparam int unsigned YPOS_W = 14;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 10;

   localparam logic OP_WRITE_CELL = 1'b0;
   localparam logic OP_READING = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SCALE = 2'd2;

   localparam logic [1:0] DIR_ROW_FWD = 2'd0;
   localparam logic [1:0] DIR_ROW_REV = 2'd1;
   localparam logic [1:0] DIR_COL_FWD = 2'd2;
   localparam logic [1:0] DIR_COL_REV = 2'd3;

   localparam logic [1:0] HEAD_EAST = 2'd0;
   localparam logic [1:0] HEAD_90 = 2'd1;
   localparam logic [1:0] HEAD_180 = 2'd2;
   localparam logic [1:0] HEAD_270 = 2'd3;

   typedef struct packed {
      logic opcode;
      logic [ROW_W-1:0] cell_row;
      logic [COL_W-1:0] cell_col;
      logic [CODE_W-1:0] color_code;
   } req_type;

   typedef struct packed {
      logic located;
      logic [XPOS_W-1:0] x_pos;
      logic [YPOS_W-1:0] y_pos;
      logic [1:0] heading;
      logic [TOT_W-1:0] total_matches;
      logic [CNT_W-1:0] row_fwd_matches;
      logic [CNT_W-1:0] row_rev_matches;
      logic [CNT_W-1:0] col_fwd_matches;
      logic [CNT_W-1:0] col_rev_matches;
      logic [5:0] reading_count;
      logic overflow;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_DATA_W-1:0] data;
   } csr_type;

   // controller to datapath
   typedef struct packed {
      logic take_req;      // latch request, write map
      logic start_search;  // append reading, clear counters and scan indices
      logic issue_read;    // read map and reading stores at current indices
      logic compare;       // compare returned data, advance
      logic finish;        // resolve location, form result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_write;
      logic search_done;
   } sts_type;

endpackage

// ===== hw/rtl/gsl_if.sv =====
interface gsl_req_if import gsl_pkg::*; ();
   logic valid;
   logic ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface gsl_rsp_if import gsl_pkg::*; ();
   logic valid;
   logic ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface gsl_csr_if import gsl_pkg::*; ();
   logic valid;
   logic ready;
   csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/gsl_ram.sv =====
module gsl_ram #(
   parameter int unsigned WIDTH = 3,
   parameter int unsigned DEPTH = 512
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/gsl_ctrl.sv =====
module gsl_ctrl import gsl_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DECIDE = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_CMP = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.is_write) begin
               state_in = ST_IDLE;
            end else begin
               cmd.start_search = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (sts.search_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.issue_read = 1'b1;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.compare = 1'b1;
            state_in = ST_READ;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== hw/rtl/gsl_dp.sv =====
module gsl_dp import gsl_pkg::*; #(
   parameter int unsigned MAX_WIDTH = 32,
   parameter int unsigned MAX_HEIGHT = 16,
   parameter int unsigned MAX_READS = 32
) (
   input  logic clock,
   input  logic reset,
   input  req_type req,
   input  logic csr_we,
   input  csr_type csr,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp
);
   localparam int unsigned XW = $clog2(MAX_WIDTH);
   localparam int unsigned YW = $clog2(MAX_HEIGHT);
   localparam int unsigned AW = XW + YW;
   localparam int unsigned RAW = $clog2(MAX_READS);
   localparam int unsigned NW = $clog2(MAX_READS + 1);
   localparam int unsigned XCW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned YCW = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned SUMW = XCW + YCW + NW + 1;

   // configuration
   logic [5:0] map_width_ff;
   logic [4:0] map_height_ff;
   logic [9:0] cell_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff <= 6'd18;
         map_height_ff <= 5'd10;
         cell_scale_ff <= 10'd100;
      end else if (csr_we) begin
         unique case (csr.index)
            CSR_MAP_WIDTH: map_width_ff <= csr.data[5:0];
            CSR_MAP_HEIGHT: map_height_ff <= csr.data[4:0];
            CSR_CELL_SCALE: cell_scale_ff <= csr.data;
            default: ;
         endcase
      end
   end

   logic [XCW-1:0] w_sat;
   logic [YCW-1:0] h_sat;
   always_comb begin
      if (map_width_ff == 6'd0) w_sat = XCW'(1);
      else if (32'(map_width_ff) > MAX_WIDTH) w_sat = XCW'(MAX_WIDTH);
      else w_sat = XCW'(map_width_ff);
      if (map_height_ff == 5'd0) h_sat = YCW'(1);
      else if (32'(map_height_ff) > MAX_HEIGHT) h_sat = YCW'(MAX_HEIGHT);
      else h_sat = YCW'(map_height_ff);
   end

   // request latch
   req_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.take_req) req_ff <= req;
   end
   assign sts.is_write = (req_ff.opcode == OP_WRITE_CELL);

   // sequence store fill
   logic [NW-1:0] n_ff;
   logic overflow_ff;
   logic append;
   assign append = cmd.start_search && (32'(n_ff) < MAX_READS);

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
      end else if (append) begin
         n_ff <= n_ff + NW'(1);
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.start_search) overflow_ff <= !append;
   end

   // scan indices
   logic [1:0] dir_ff;
   logic [XCW-1:0] x_ff;
   logic [YCW-1:0] y_ff;
   logic [NW-1:0] i_ff;
   logic ok_ff, done_ff, skip_ff;
   logic [XCW-1:0] xs;
   logic [YCW-1:0] ys;
   logic [NW-1:0] n_use;
   assign n_use = n_ff;

   always_comb begin
      if (dir_ff[1] == 1'b0) begin
         xs = (32'(n_use) <= 32'(w_sat)) ? XCW'(32'(w_sat) - 32'(n_use) + 1) : '0;
         ys = h_sat;
      end else begin
         xs = w_sat;
         ys = (32'(n_use) <= 32'(h_sat)) ? YCW'(32'(h_sat) - 32'(n_use) + 1) : '0;
      end
   end

   // memories
   logic map_we;
   logic [AW-1:0] map_waddr, map_raddr;
   logic [CODE_W-1:0] map_rdata, seq_rdata;
   logic [RAW-1:0] seq_raddr;
   logic [XCW-1:0] cx;
   logic [YCW-1:0] cy;

   assign map_we = cmd.take_req && (req.opcode == OP_WRITE_CELL)
                   && (32'(req.cell_row) < MAX_HEIGHT) && (32'(req.cell_col) < MAX_WIDTH);
   assign map_waddr = {YW'(req.cell_row), XW'(req.cell_col)};

   always_comb begin
      if (dir_ff[1] == 1'b0) begin
         cx = XCW'(32'(x_ff) + 32'(i_ff));
         cy = y_ff;
      end else begin
         cx = x_ff;
         cy = YCW'(32'(y_ff) + 32'(i_ff));
      end
      if (dir_ff[0]) seq_raddr = RAW'(32'(n_use) - 1 - 32'(i_ff));
      else seq_raddr = RAW'(i_ff);
   end
   assign map_raddr = {cy[YW-1:0], cx[XW-1:0]};

   gsl_ram #(.WIDTH(CODE_W), .DEPTH(2 ** AW)) u_map (
      .clock(clock), .wr_en(map_we), .wr_addr(map_waddr), .wr_data(req.color_code),
      .rd_addr(map_raddr), .rd_data(map_rdata)
   );

   gsl_ram #(.WIDTH(CODE_W), .DEPTH(MAX_READS)) u_seq (
      .clock(clock), .wr_en(append), .wr_addr(n_ff[RAW-1:0]),
      .wr_data(req_ff.color_code), .rd_addr(seq_raddr), .rd_data(seq_rdata)
   );

   // counters and hit
   logic [CNT_W-1:0] cnt_ff [4];
   logic [1:0] hit_dir_ff;
   logic [XCW-1:0] hit_x_ff;
   logic [YCW-1:0] hit_y_ff;
   logic match_bit, win_last;
   assign match_bit = (map_rdata == seq_rdata);
   assign win_last = (32'(i_ff) + 1 >= 32'(n_use));

   assign sts.search_done = done_ff;

   always_ff @(posedge clock) begin
      if (cmd.start_search) begin
         dir_ff <= DIR_ROW_FWD;
         x_ff <= '0;
         y_ff <= '0;
         i_ff <= '0;
         ok_ff <= 1'b1;
         done_ff <= 1'b0;
         for (int d = 0; d < 4; d++) cnt_ff[d] <= '0;
      end else if (cmd.issue_read) begin
         skip_ff <= (xs == '0 || ys == '0);
         // empty orientation: skip it
         if (xs == '0 || ys == '0) begin
            if (dir_ff == DIR_COL_REV) done_ff <= 1'b1;
            dir_ff <= dir_ff + 2'd1;
         end
      end else if (cmd.compare) begin
         if (!skip_ff) begin
            if (!win_last && ok_ff && match_bit) begin
               i_ff <= i_ff + NW'(1);
            end else begin
               if (ok_ff && match_bit) begin
                  cnt_ff[dir_ff] <= cnt_ff[dir_ff] + CNT_W'(1);
                  hit_dir_ff <= dir_ff;
                  hit_x_ff <= x_ff;
                  hit_y_ff <= y_ff;
               end
               i_ff <= '0;
               ok_ff <= 1'b1;
               if (32'(x_ff) + 1 < 32'(xs)) begin
                  x_ff <= x_ff + XCW'(1);
               end else begin
                  x_ff <= '0;
                  if (32'(y_ff) + 1 < 32'(ys)) begin
                     y_ff <= y_ff + YCW'(1);
                  end else begin
                     y_ff <= '0;
                     if (dir_ff == DIR_COL_REV) done_ff <= 1'b1;
                     dir_ff <= dir_ff + 2'd1;
                  end
               end
            end
         end
      end
   end

   // location
   logic [TOT_W-1:0] total;
   assign total = TOT_W'(cnt_ff[0]) + TOT_W'(cnt_ff[1]) + TOT_W'(cnt_ff[2])
                  + TOT_W'(cnt_ff[3]);

   logic [COL_W-1:0] last_col_ff;
   logic [ROW_W-1:0] last_row_ff;
   logic [1:0] last_head_ff;
   logic [SUMW-1:0] fx, fy;
   assign fx = SUMW'(hit_x_ff) + SUMW'(n_use) - SUMW'(1);
   assign fy = SUMW'(hit_y_ff) + SUMW'(n_use) - SUMW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= '0;
         last_row_ff <= '0;
         last_head_ff <= HEAD_EAST;
      end else if (cmd.finish && total == TOT_W'(1)) begin
         unique case (hit_dir_ff)
            DIR_ROW_FWD: begin
               last_col_ff <= fx[COL_W-1:0];
               last_row_ff <= ROW_W'(hit_y_ff);
               last_head_ff <= HEAD_EAST;
            end
            DIR_ROW_REV: begin
               last_col_ff <= COL_W'(hit_x_ff);
               last_row_ff <= ROW_W'(hit_y_ff);
               last_head_ff <= HEAD_180;
            end
            DIR_COL_FWD: begin
               last_col_ff <= COL_W'(hit_x_ff);
               last_row_ff <= fy[ROW_W-1:0];
               last_head_ff <= HEAD_90;
            end
            default: begin
               last_col_ff <= COL_W'(hit_x_ff);
               last_row_ff <= ROW_W'(hit_y_ff);
               last_head_ff <= HEAD_270;
            end
         endcase
      end
   end

   logic located_ff;
   always_ff @(posedge clock) begin
      if (cmd.finish) located_ff <= (total == TOT_W'(1));
   end

   logic [14:0] xp;
   logic [13:0] yp;
   assign xp = 15'(last_col_ff * cell_scale_ff);
   assign yp = 14'(last_row_ff * cell_scale_ff);

   always_comb begin
      rsp.located = located_ff;
      rsp.x_pos = xp;
      rsp.y_pos = yp;
      rsp.heading = last_head_ff;
      rsp.total_matches = total;
      rsp.row_fwd_matches = cnt_ff[0];
      rsp.row_rev_matches = cnt_ff[1];
      rsp.col_fwd_matches = cnt_ff[2];
      rsp.col_rev_matches = cnt_ff[3];
      rsp.reading_count = 6'(n_ff);
      rsp.overflow = overflow_ff;
   end
endmodule

// ===== hw/rtl/grid_sequence_localizer_unit.sv =====
// channel  | direction | payload
// req      | in        | opcode, cell_row, cell_col, color_code
// rsp      | out       | location, match counts, reading count, overflow
// csr      | in        | register index, write data
// a cell write: idle and decide states; a reading: read and compare states per
// map cell compared (each window stops at its first mismatch) and per empty
// orientation, then finish and output, as the one map read port scans each cell
// reset: synchronous, readings cleared, location zero, registers at defaults
// a stalled response holds the block; no new request is taken until it goes
module grid_sequence_localizer_unit import gsl_pkg::*; #(
   parameter int unsigned MAX_WIDTH = 32,
   parameter int unsigned MAX_HEIGHT = 16,
   parameter int unsigned MAX_READS = 32
) (
   input logic clock,
   input logic reset,
   gsl_req_if.sink req_ch,
   gsl_rsp_if.source rsp_ch,
   gsl_csr_if.sink csr_ch
);
   cmd_type cmd;
   sts_type sts;

   assign csr_ch.ready = 1'b1;

   gsl_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .sts(sts), .cmd(cmd)
   );

   gsl_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_READS(MAX_READS)) u_dp (
      .clock(clock), .reset(reset), .req(req_ch.payload),
      .csr_we(csr_ch.valid), .csr(csr_ch.payload),
      .cmd(cmd), .sts(sts), .rsp(rsp_ch.payload)
   );
endmodule

// ===== hw/rtl/gsl_checker.sv =====
module gsl_checker import gsl_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_type rsp
);
   // response stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped");

   // no request taken while a response waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken during response");

   // total is the sum of the four counts
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.total_matches == TOT_W'(rsp.row_fwd_matches)
         + TOT_W'(rsp.row_rev_matches) + TOT_W'(rsp.col_fwd_matches)
         + TOT_W'(rsp.col_rev_matches))
      else $error("total mismatch");

   // located exactly when one match
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.located == (rsp.total_matches == TOT_W'(1)))
      else $error("located flag wrong");
endmodule

bind grid_sequence_localizer_unit gsl_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_ch.valid), .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .rsp(rsp_ch.payload)
);
